/* rtl/vgpd_pkg.sv */
`default_nettype none
package vgpd_pkg;
   localparam int unsigned TableEntriesDefault = 4096;
   localparam int unsigned CoordWidth = 32;
   localparam int unsigned EdgeWidth = 31;
   localparam logic [EdgeWidth-1:0] EdgeReset = 31'd3277;
   localparam int unsigned KeyWidth = 3 * CoordWidth;

   typedef enum logic [6:0] {
      ST_CLEAR  = 7'b0000001,
      ST_IDLE   = 7'b0000010,
      ST_DIV    = 7'b0000100,
      ST_READ   = 7'b0001000,
      ST_CHECK  = 7'b0010000,
      ST_EMIT   = 7'b0100000,
      ST_FLUSH  = 7'b1000000
   } state_type;

   typedef struct packed {
      logic load;
      logic div_start;
      logic probe_init;
      logic probe_next;
      logic write_slot;
      logic clear_step;
      logic clear_begin;
      logic out_load;
   } cmd_type;

   typedef struct packed {
      logic div_done;
      logic slot_valid;
      logic key_match;
      logic table_full;
      logic probe_wrapped;
      logic clear_done;
   } stat_type;
endpackage
`default_nettype wire

/* rtl/voxel_grid_point_dedup.sv */
`default_nettype none
// Voxel-grid point deduplication. Each request carries one Q16.16 point; its
// coordinates are divided by csr_wdata's voxel edge (truncated toward zero,
// edge 0 acts as 1) to form a voxel key, which is looked up in a linearly
// probed hash table of TABLE_ENTRIES slots (a power of two). The first point
// of each voxel is forwarded in arrival order; repeats are dropped. If the
// table is full and the key is new, the point passes with rsp_tuser set and
// the table is left as it is. Valid bits sit in a RAM wiped one slot a cycle:
// after reset req_tready stays low until the wipe is done, and a request
// with req_tuser set waits out the same wipe (its divide runs alongside)
// before its lookup. One request is in flight at a time. The three parallel
// bit-serial dividers hand over the key; then slots are probed in turn, each
// through a registered RAM read, and the result is loaded into the output
// register. A point placed at its home slot raises rsp_tvalid and req_tready
// returns in that same cycle; a dropped point frees the input without being
// forwarded. A miss in a full table walks every slot. A result held by
// rsp_tready delays the load of the next result and keeps the input closed
// while that load waits.
module voxel_grid_point_dedup #(
   parameter int unsigned TABLE_ENTRIES = vgpd_pkg::TableEntriesDefault
) (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         csr_we,
   input  wire logic [30:0]  csr_wdata,   // voxel_edge
   input  wire logic         req_tvalid,
   output logic              req_tready,
   input  wire logic [151:0] req_tdata,   // pos_x, pos_y, pos_z, rgb, point_tag
   input  wire logic         req_tuser,   // first_of_set
   output logic              rsp_tvalid,
   input  wire logic         rsp_tready,
   output logic      [151:0] rsp_tdata,   // kept_x,kept_y,kept_z,kept_rgb,kept_tag
   output logic              rsp_tuser    // table_overflow
);
   import vgpd_pkg::*;
   logic [EdgeWidth-1:0] edge_ff;
   cmd_type  cmd;
   stat_type stat;

   always_ff @(posedge clock) begin
      if (reset) edge_ff <= EdgeReset;
      else if (csr_we) edge_ff <= csr_wdata;
   end

   vgpd_ctrl u_ctrl (
      .clock(clock), .reset(reset), .req_tvalid(req_tvalid),
      .req_tready(req_tready), .req_first(req_tuser), .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready), .cmd(cmd), .stat(stat)
   );

   vgpd_datapath #(.TableEntries(TABLE_ENTRIES)) u_dp (
      .clock(clock), .reset(reset), .cmd(cmd), .stat(stat), .edge_len(edge_ff),
      .req_tdata(req_tdata),
      .rsp_tdata(rsp_tdata), .rsp_tuser(rsp_tuser)
   );
endmodule
`default_nettype wire

/* rtl/vgpd_ram.sv */
`default_nettype none
module vgpd_ram #(
   parameter int unsigned Width = 8,
   parameter int unsigned Depth = 16
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(Depth)-1:0] wr_addr,
   input  wire logic [Width-1:0]         wr_data,
   input  wire logic [$clog2(Depth)-1:0] rd_addr,
   output logic      [Width-1:0]         rd_data
);
   logic [Width-1:0] mem [Depth];
   always_ff @(posedge clock) begin
      if (wr_en) mem[wr_addr] <= wr_data;
      rd_data <= mem[rd_addr];
   end
endmodule
`default_nettype wire

/* rtl/vgpd_datapath.sv */
`default_nettype none
module vgpd_datapath #(
   parameter int unsigned TableEntries = vgpd_pkg::TableEntriesDefault
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire vgpd_pkg::cmd_type             cmd,
   output vgpd_pkg::stat_type                 stat,
   input  wire logic [vgpd_pkg::EdgeWidth-1:0] edge_len,
   input  wire logic [151:0]                  req_tdata,
   output logic      [151:0]                  rsp_tdata,
   output logic                               rsp_tuser
);
   import vgpd_pkg::*;
   localparam int unsigned AW = $clog2(TableEntries);
   localparam int unsigned CW = AW + 1;

   // captured request
   logic [151:0] item_ff;
   // divider: three restoring dividers in parallel, one quotient bit a cycle
   logic [31:0] mag_ff [3];
   logic [31:0] rem_ff [3];
   logic        neg_ff [3];
   logic [31:0] dvs_ff;
   logic [5:0]  cnt_ff;
   logic        busy_ff;
   logic        key_ok_ff;
   logic [KeyWidth-1:0] key_ff;
   // probe state
   logic [AW-1:0] slot_ff, clr_ff;
   logic [CW-1:0] used_ff, steps_ff;
   logic          clr_busy_ff;
   logic          ins_ff;
   logic          rd_vld;
   logic          vld_we, vld_wdata;
   logic [AW-1:0] vld_waddr;
   logic [KeyWidth-1:0]     rd_key;
   logic [151:0] out_ff;
   logic         ovf_ff;

   logic [AW-1:0] home;
   logic [31:0]   kx, ky, kz, h;

   always_comb begin
      kx = key_ff[31:0];
      ky = key_ff[63:32];
      kz = key_ff[95:64];
      h = kx ^ (ky << 1) ^ (kz << 2);
      home = h[AW-1:0];
   end

   always_ff @(posedge clock) begin
      if (cmd.load) item_ff <= req_tdata;
      if (cmd.div_start) begin
         for (int i = 0; i < 3; i++) begin
            neg_ff[i] <= req_tdata[32*i+31];
            mag_ff[i] <= req_tdata[32*i+31] ? 32'(-req_tdata[32*i +: 32])
                                            : req_tdata[32*i +: 32];
            rem_ff[i] <= '0;
         end
         dvs_ff <= (edge_len == '0) ? 32'd1 : {1'b0, edge_len};
         cnt_ff <= 6'd0;
      end else if (busy_ff) begin
         for (int i = 0; i < 3; i++) begin
            logic [32:0] t;
            t = {rem_ff[i], mag_ff[i][31]};
            if (t >= {1'b0, dvs_ff}) begin
               rem_ff[i] <= 32'(t - {1'b0, dvs_ff});
               mag_ff[i] <= {mag_ff[i][30:0], 1'b1};
            end else begin
               rem_ff[i] <= t[31:0];
               mag_ff[i] <= {mag_ff[i][30:0], 1'b0};
            end
         end
         cnt_ff <= cnt_ff + 6'd1;
      end
      if (busy_ff && cnt_ff == 6'd32) begin
         for (int i = 0; i < 3; i++)
            key_ff[32*i +: 32] <= neg_ff[i] ? 32'(-mag_ff[i]) : mag_ff[i];
      end
   end

   // key_ok_ff holds until the next request so a table wipe can outlast the divide
   always_ff @(posedge clock) begin
      if (reset) busy_ff <= 1'b0;
      else if (cmd.div_start) busy_ff <= 1'b1;
      else if (cnt_ff == 6'd32) busy_ff <= 1'b0;
      if (reset || cmd.div_start) key_ok_ff <= 1'b0;
      else if (busy_ff && cnt_ff == 6'd32) key_ok_ff <= 1'b1;
   end

   // valid bits live in a RAM, wiped one slot per clear_step
   always_ff @(posedge clock) begin
      if (reset || cmd.clear_begin) begin
         clr_busy_ff <= 1'b1;
         clr_ff <= '0;
         used_ff <= '0;
      end else begin
         if (cmd.clear_step) begin
            clr_ff <= clr_ff + AW'(1);
            if (clr_ff == AW'(TableEntries - 1)) clr_busy_ff <= 1'b0;
         end
         if (cmd.write_slot) used_ff <= used_ff + CW'(1);
      end
      if (cmd.probe_init) begin
         slot_ff <= home;
         steps_ff <= '0;
      end else if (cmd.probe_next) begin
         slot_ff <= slot_ff + AW'(1);
         steps_ff <= steps_ff + CW'(1);
      end
      if (cmd.load) ins_ff <= 1'b0;
      else if (cmd.write_slot) ins_ff <= 1'b1;
      if (cmd.out_load) begin
         out_ff <= item_ff;
         ovf_ff <= !ins_ff;
      end
   end

   always_comb begin
      vld_we    = cmd.clear_step || cmd.write_slot;
      vld_waddr = cmd.clear_step ? clr_ff : slot_ff;
      vld_wdata = !cmd.clear_step;
   end

   vgpd_ram #(.Width(1), .Depth(TableEntries)) u_valid (
      .clock  (clock),
      .wr_en  (vld_we),
      .wr_addr(vld_waddr),
      .wr_data(vld_wdata),
      .rd_addr(slot_ff),
      .rd_data(rd_vld)
   );

   vgpd_ram #(.Width(KeyWidth), .Depth(TableEntries)) u_keys (
      .clock  (clock),
      .wr_en  (cmd.write_slot),
      .wr_addr(slot_ff),
      .wr_data(key_ff),
      .rd_addr(slot_ff),
      .rd_data(rd_key)
   );

   always_comb begin
      stat.div_done      = key_ok_ff;
      stat.slot_valid    = rd_vld;
      stat.key_match     = rd_key == key_ff;
      stat.table_full    = used_ff == CW'(TableEntries);
      stat.probe_wrapped = steps_ff == CW'(TableEntries - 1);
      stat.clear_done    = !clr_busy_ff;
      rsp_tdata = out_ff;
      rsp_tuser = ovf_ff;
   end
endmodule
`default_nettype wire

/* rtl/vgpd_ctrl.sv */
`default_nettype none
module vgpd_ctrl (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_tvalid,
   output logic                    req_tready,
   input  wire logic               req_first,
   output logic                    rsp_tvalid,
   input  wire logic               rsp_tready,
   output vgpd_pkg::cmd_type       cmd,
   input  wire vgpd_pkg::stat_type stat
);
   import vgpd_pkg::*;
   state_type state_ff, state_in;
   logic vld_ff, vld_in;
   logic take;

   always_comb begin
      state_in = state_ff;
      vld_in = vld_ff;
      cmd = '0;
      req_tready = (state_ff == ST_IDLE);
      take = req_tvalid && req_tready;
      if (rsp_tvalid && rsp_tready) vld_in = 1'b0;
      case (state_ff)
         ST_IDLE: if (take) begin
            cmd.load = 1'b1;
            cmd.div_start = 1'b1;
            cmd.clear_begin = req_first;
            state_in = ST_DIV;
         end
         ST_DIV: begin
            // a set's first point wipes the table while its key is divided
            cmd.clear_step = !stat.clear_done;
            if (stat.div_done && stat.clear_done) state_in = ST_READ;
         end
         ST_READ: begin
            cmd.probe_init = 1'b1;
            state_in = ST_CHECK;
         end
         ST_CHECK: begin
            // a wait state for the registered key read
            state_in = ST_EMIT;
         end
         ST_EMIT: begin
            if (!stat.slot_valid) begin
               if (!stat.table_full) cmd.write_slot = 1'b1;
               state_in = ST_FLUSH;
            end else if (stat.key_match) begin
               state_in = ST_IDLE;
            end else if (stat.probe_wrapped) begin
               state_in = ST_FLUSH;
            end else begin
               cmd.probe_next = 1'b1;
               state_in = ST_CHECK;
            end
         end
         ST_FLUSH: if (!vld_ff || (rsp_tvalid && rsp_tready)) begin
            cmd.out_load = 1'b1;
            vld_in = 1'b1;
            state_in = ST_IDLE;
         end
         ST_CLEAR: begin
            // wipe after reset
            cmd.clear_step = !stat.clear_done;
            if (stat.clear_done) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   assign rsp_tvalid = vld_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
         vld_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         vld_ff <= vld_in;
      end
   end

   a_onehot: assert property (@(posedge clock) disable iff (reset) $onehot(state_ff))
      else $error("state not one-hot");
   a_nowr: assert property (@(posedge clock) disable iff (reset)
      cmd.write_slot |-> !stat.table_full) else $error("write to full table");
   a_out: assert property (@(posedge clock) disable iff (reset)
      cmd.out_load |=> rsp_tvalid) else $error("result lost");
endmodule
`default_nettype wire
